FILE: hw/rtl/twsm_pkg.sv
// Shared types, codes and default sizes for the three-wire serial master.
package twsm_pkg;

    // Default frame sizes
    localparam int WRITE_FRAME_BITS_DEF = 16;
    localparam int READ_DATA_BITS_DEF   = 12;
    localparam int READ_ADDR_BITS_DEF   = 5;

    // Fixed field widths of the request and result items
    localparam int MODE_W  = 2;
    localparam int ADDR_W  = 5;
    localparam int WDATA_W = 12;
    localparam int RDATA_W = 12;
    localparam int WR_ADDR_W = 4;            // address bits carried by a write frame

    localparam int S_TDATA_W = 24;           // 18 used bits, padded to bytes
    localparam int M_TDATA_W = 24;           // 18 used bits, padded to bytes

    // Request kinds carried in tuser
    localparam logic [MODE_W-1:0] MODE_TICK  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_WRITE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_READ  = 2'd2;

    // Frame kind
    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_READ  = 1'b1;

    // Frame segments
    typedef enum logic [5:0] {
        SEG_LEAD0 = 6'b000001,   // enable still high
        SEG_LEAD1 = 6'b000010,   // enable drops
        SEG_SHIFT = 6'b000100,   // 3-tick bit slots out of the send shifter
        SEG_TURN  = 6'b001000,   // line turnaround before read-back
        SEG_DATA  = 6'b010000,   // 5-tick sample slots
        SEG_TAIL  = 6'b100000    // enable back high
    } seg_t;

    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic [ADDR_W-1:0]  reg_addr;
        logic [WDATA_W-1:0] write_data;
        logic               sense_bit;
    } req_t;

    typedef struct packed {
        logic               pin_enable;
        logic               pin_clock;
        logic               pin_data;
        logic               data_released;
        logic               busy_res;
        logic               done_res;
        logic [RDATA_W-1:0] read_data;
        logic               rejected;
    } res_t;

endpackage

FILE: hw/rtl/twsm_seq.sv
// Frame sequencer: frame state plus the pin logic for one tick.
module twsm_seq
    import twsm_pkg::*;
#(
    parameter int WRITE_FRAME_BITS = WRITE_FRAME_BITS_DEF,
    parameter int READ_DATA_BITS   = READ_DATA_BITS_DEF,
    parameter int READ_ADDR_BITS   = READ_ADDR_BITS_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic step,          // apply the tick in req
    input  req_t req,
    output res_t res
);

    localparam int W = WRITE_FRAME_BITS;
    localparam int D = READ_DATA_BITS;
    localparam int R = READ_ADDR_BITS;
    localparam int MAX_BITS = (W > D) ? W : D;
    localparam int BIT_W = $clog2(MAX_BITS);

    localparam logic [BIT_W-1:0] WBIT_TOP = BIT_W'(W - 1);
    localparam logic [BIT_W-1:0] RBIT_TOP = BIT_W'(R - 1);
    localparam logic [BIT_W-1:0] DBIT_TOP = BIT_W'(D - 1);

    logic             active_reg, active_next;
    logic             kind_reg,   kind_next;
    seg_t             seg_reg,    seg_next;
    logic [2:0]       sub_reg,    sub_next;
    logic [BIT_W-1:0] bit_reg,    bit_next;
    logic [W-1:0]     send_reg,   send_next;
    logic [D-1:0]     recv_reg,   recv_next;

    logic [W+WDATA_W+WR_ADDR_W-1:0] frame_wide;
    logic [W+ADDR_W-1:0]            addr_wide;
    logic [W+ADDR_W-1:0]            addr_mask;
    logic [D+RDATA_W-1:0]           rd_wide;
    logic [W-1:0]                   send_load;
    logic [W-1:0]                   send_sel;

    always_comb
    begin
        frame_wide = {{W{1'b0}}, req.write_data, req.reg_addr[WR_ADDR_W-1:0]};
        addr_mask  = ~({(W+ADDR_W){1'b1}} << R);
        addr_wide  = {{W{1'b0}}, req.reg_addr} & addr_mask;
        send_load  = (req.mode == MODE_WRITE) ? frame_wide[W-1:0] : addr_wide[W-1:0];
    end

    always_comb
    begin
        logic start;
        logic load;
        logic setup_first;
        logic en, sclk, dat, rel, done;

        start = (req.mode == MODE_WRITE) || (req.mode == MODE_READ);
        load  = start && !active_reg;

        // State as seen by this tick (a start while no frame is active loads a fresh frame)
        active_next = active_reg || load;
        kind_next   = load ? ((req.mode == MODE_READ) ? KIND_READ : KIND_WRITE) : kind_reg;
        seg_next    = load ? SEG_LEAD0 : seg_reg;
        sub_next    = load ? 3'd0 : sub_reg;
        bit_next    = bit_reg;
        send_next   = load ? send_load : send_reg;
        recv_next   = load ? '0 : recv_reg;

        en   = 1'b1;
        sclk = 1'b0;
        dat  = 1'b0;
        rel  = 1'b0;
        done = 1'b0;
        setup_first = 1'b0;
        send_sel = send_next >> bit_next;

        if (active_next)
        begin
            unique case (seg_next)
                SEG_LEAD0:
                begin
                    seg_next = SEG_LEAD1;
                end
                SEG_LEAD1:
                begin
                    en       = 1'b0;
                    seg_next = SEG_SHIFT;
                    sub_next = 3'd0;
                    bit_next = (kind_next == KIND_WRITE) ? WBIT_TOP : RBIT_TOP;
                end
                SEG_SHIFT:
                begin
                    en  = 1'b0;
                    dat = send_sel[0];
                    // write: odd bits set up first; read: even bits
                    setup_first = (bit_next[0] == (kind_next == KIND_WRITE));
                    sclk = setup_first ? (sub_next != 3'd0) : (sub_next != 3'd2);
                    if (sub_next == 3'd2)
                    begin
                        sub_next = 3'd0;
                        if (bit_next == '0)
                            seg_next = (kind_next == KIND_WRITE) ? SEG_TAIL : SEG_TURN;
                        else
                            bit_next = bit_next - 1'b1;
                    end
                    else
                        sub_next = sub_next + 3'd1;
                end
                SEG_TURN:
                begin
                    en   = 1'b0;
                    rel  = 1'b1;
                    sclk = (sub_next == 3'd0);
                    if (sub_next == 3'd2)
                    begin
                        seg_next = SEG_DATA;
                        sub_next = 3'd0;
                        bit_next = DBIT_TOP;
                    end
                    else
                        sub_next = sub_next + 3'd1;
                end
                SEG_DATA:
                begin
                    en   = 1'b0;
                    rel  = 1'b1;
                    sclk = (sub_next >= 3'd1) && (sub_next <= 3'd3);
                    if (sub_next == 3'd3)
                        recv_next = {recv_next[D-2:0], req.sense_bit};
                    if (sub_next == 3'd4)
                    begin
                        sub_next = 3'd0;
                        if (bit_next == '0)
                            seg_next = SEG_TAIL;
                        else
                            bit_next = bit_next - 1'b1;
                    end
                    else
                        sub_next = sub_next + 3'd1;
                end
                SEG_TAIL:
                begin
                    rel = (kind_next == KIND_READ);
                    // write tail is two ticks, read tail one
                    if ((kind_next == KIND_READ) || (sub_next == 3'd1))
                        done = 1'b1;
                    sub_next = sub_next + 3'd1;
                end
                default:
                begin
                    seg_next = SEG_LEAD0;
                end
            endcase
        end

        active_next = active_next && !done;
        rd_wide     = {{RDATA_W{1'b0}}, recv_next};

        res.pin_enable    = en;
        res.pin_clock     = sclk;
        res.pin_data      = dat;
        res.data_released = rel;
        res.busy_res      = active_next;
        res.done_res      = done;
        res.read_data     = (done && (kind_next == KIND_READ)) ? rd_wide[RDATA_W-1:0] : '0;
        res.rejected      = start && active_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            kind_reg   <= KIND_WRITE;
            seg_reg    <= SEG_LEAD0;
            sub_reg    <= 3'd0;
            bit_reg    <= '0;
        end
        else if (step)
        begin
            active_reg <= active_next;
            kind_reg   <= kind_next;
            seg_reg    <= seg_next;
            sub_reg    <= sub_next;
            bit_reg    <= bit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            send_reg <= send_next;
            recv_reg <= recv_next;
        end
    end

endmodule

FILE: hw/rtl/three_wire_rf_serial_master.sv
// Top level of the three-wire RF register bus master: request/result registers around the sequencer.
//
//  channel  | dir | handshake          | payload
//  ---------+-----+--------------------+-------------------------------------------------
//  s_*      | in  | s_tvalid/s_tready  | tuser: mode; tdata: reg_addr, write_data, sense_bit
//  m_*      | out | m_tvalid/m_tready  | tdata: pin levels, busy, read_data, rejected; tlast: done
//
//  One request is one bus tick and yields exactly one result.
//  Throughput is one request per clock while the result is not stalled: the
//  request register feeds the sequencer logic, whose result is registered in the output register.
//  The result of an accepted request passes through the request register and
//  then the output register, where it is held until m_tready takes it.
//  rst_n clears the frame state and both valid flags; the bus starts idle.
//  A stalled m_tready holds the result; one more request is still taken into
//  the request register, after which s_tready drops until the result drains.
module three_wire_rf_serial_master
    import twsm_pkg::*;
#(
    parameter int WRITE_FRAME_BITS = WRITE_FRAME_BITS_DEF,
    parameter int READ_DATA_BITS   = READ_DATA_BITS_DEF,
    parameter int READ_ADDR_BITS   = READ_ADDR_BITS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // reg_addr[4:0], write_data[16:5], sense_bit[17], zero pad
    input  logic [MODE_W-1:0]    s_tuser,   // mode[1:0]

    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // pin_enable[0], pin_clock[1], pin_data[2],
                                            // data_released[3], busy_res[4], read_data[16:5],
                                            // rejected[17], zero pad
    output logic                 m_tlast    // done_res
);

    logic in_valid_reg;
    req_t in_req_reg;
    logic out_valid_reg;
    res_t out_res_reg;
    logic advance;
    res_t seq_res;

    // The request register moves on whenever the result slot is free or draining
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || !out_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
                in_valid_reg <= s_tvalid;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_req_reg.mode       <= s_tuser;
            in_req_reg.reg_addr   <= s_tdata[ADDR_W-1:0];
            in_req_reg.write_data <= s_tdata[ADDR_W+WDATA_W-1:ADDR_W];
            in_req_reg.sense_bit  <= s_tdata[ADDR_W+WDATA_W];
        end
        if (advance)
            out_res_reg <= seq_res;
    end

    // Frame state advances exactly once per request, when it leaves the request register
    twsm_seq #(
        .WRITE_FRAME_BITS (WRITE_FRAME_BITS),
        .READ_DATA_BITS   (READ_DATA_BITS),
        .READ_ADDR_BITS   (READ_ADDR_BITS)
    ) u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (advance),
        .req   (in_req_reg),
        .res   (seq_res)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_res_reg.done_res;
    assign m_tdata  = {{(M_TDATA_W - 6 - RDATA_W){1'b0}},
                       out_res_reg.rejected,
                       out_res_reg.read_data,
                       out_res_reg.busy_res,
                       out_res_reg.data_released,
                       out_res_reg.pin_data,
                       out_res_reg.pin_clock,
                       out_res_reg.pin_enable};

endmodule

FILE: hw/rtl/twsm_check.sv
// Port-level checker for the three-wire serial master, bound to the top level.
module twsm_check
    import twsm_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic                 m_tlast
);

    // Stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed while stalled");

    // A frame end leaves the bus not busy
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> !m_tdata[4])
        else $error("busy after last tick of frame");

    // Outside a frame the pins sit at idle levels
    a_idle_pins: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[4] && !m_tlast |-> m_tdata[0] && !m_tdata[1] && !m_tdata[2]
                                               && !m_tdata[3])
        else $error("pins not idle outside a frame");

    // Released data line is never driven
    a_released: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[3] |-> !m_tdata[2])
        else $error("data driven while released");

    // Read value only shows on a frame end
    a_rdata: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tlast |-> (m_tdata[16:5] == '0))
        else $error("read data outside frame end");

endmodule

bind three_wire_rf_serial_master twsm_check u_twsm_check (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
